// File: design/tqbp_pkg.sv
// shared types and constants for the ternary quantiser and bit-plane packer
// no dependencies; imported by every module of the block
package tqbp_pkg;

  // sizing
  localparam int MAX_CHANNELS = 4096;
  localparam int WORD_BITS    = 64;
  localparam int BIT_W        = $clog2(WORD_BITS);
  localparam int SAMPLE_W     = 16;
  localparam int THRESH_W     = 15;
  localparam int COUNT_W      = 13;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  // largest channel count the count register can hold after saturation
  localparam int COUNT_CAP = (MAX_CHANNELS < (2 ** COUNT_W) - 1) ?
                             MAX_CHANNELS : (2 ** COUNT_W) - 1;

  // reset values: threshold zero, channel count 64
  localparam logic [THRESH_W-1:0] THRESH_RESET    = '0;
  localparam logic [COUNT_W-1:0]  LAST_CH_RESET   = COUNT_W'(63);
  localparam logic [COUNT_W-1:0]  LAST_CH_CAP     = COUNT_W'(COUNT_CAP - 1);
  localparam logic [BIT_W-1:0]    LAST_BIT        = BIT_W'(WORD_BITS - 1);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD     = 2'd0,
    REG_CHANNEL_COUNT = 2'd1
  } cfg_reg_t;

  typedef logic [WORD_BITS-1:0] word_t;

  // one ternarised sample handed from the input stage to the packer
  typedef struct packed {
    logic valid;
    logic neg;
    logic nz;
  } tqbp_trit_t;

endpackage

// File: design/tqbp_cfg.sv
// configuration registers: threshold and last channel index of a position
// depends on tqbp_pkg
module tqbp_cfg
  import tqbp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [THRESH_W-1:0]   threshold,
  output logic [COUNT_W-1:0]    last_channel
);

  logic [THRESH_W-1:0] threshold_r;
  logic [COUNT_W-1:0]  last_r;
  logic [COUNT_W-1:0]  count_w;
  logic [COUNT_W-1:0]  last_nxt;

  assign cfg_ready = 1'b1;
  assign count_w   = cfg_data[COUNT_W-1:0];

  // channel count clamped to 1..cap, stored as last index
  always_comb begin
    if (count_w == '0) begin
      last_nxt = '0;
    end else if (count_w > COUNT_W'(COUNT_CAP)) begin
      last_nxt = LAST_CH_CAP;
    end else begin
      last_nxt = count_w - COUNT_W'(1);
    end
  end

  // register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESH_RESET;
      last_r      <= LAST_CH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_THRESHOLD:     threshold_r <= cfg_data[THRESH_W-1:0];
        REG_CHANNEL_COUNT: last_r      <= last_nxt;
        default: ;
      endcase
    end
  end

  assign threshold    = threshold_r;
  assign last_channel = last_r;

endmodule

// File: design/tqbp_in_stage.sv
// input register and ternary decision against the threshold
// depends on tqbp_pkg
module tqbp_in_stage
  import tqbp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  logic                in_is_pad,
  input  logic [THRESH_W-1:0] threshold,
  input  logic                take,
  output tqbp_trit_t          trit
);

  logic                valid_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic                pad_r;

  logic signed [SAMPLE_W:0] s_ext;
  logic signed [SAMPLE_W:0] t_pos;
  logic signed [SAMPLE_W:0] t_neg;
  logic                     above;
  logic                     below;

  assign in_ready = !valid_r || take;

  // input beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sample_r <= in_sample;
      pad_r    <= in_is_pad;
    end
  end

  // signed compares against +threshold and -threshold
  assign s_ext = $signed({sample_r[SAMPLE_W-1], sample_r});
  assign t_pos = $signed({{(SAMPLE_W + 1 - THRESH_W){1'b0}}, threshold});
  assign t_neg = -t_pos;
  assign above = s_ext > t_pos;
  assign below = s_ext < t_neg;

  always_comb begin
    trit.valid = valid_r;
    trit.neg   = !pad_r && !above && below;
    trit.nz    = !pad_r && (above || below);
  end

endmodule

// File: design/tqbp_pack.sv
// bit-plane accumulators, word and position counters, result register
// depends on tqbp_pkg
module tqbp_pack
  import tqbp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  tqbp_trit_t         trit,
  input  logic [COUNT_W-1:0] last_channel,
  output logic               take,
  output logic               out_valid,
  input  logic               out_ready,
  output word_t              out_negative_mask,
  output word_t              out_nonzero_mask,
  output logic               out_last_of_position
);

  logic [BIT_W-1:0]   bit_r;
  logic [COUNT_W-1:0] idx_r;
  word_t              neg_acc_r;
  word_t              nz_acc_r;
  logic               out_valid_r;
  word_t              out_neg_r;
  word_t              out_nz_r;
  logic               out_last_r;

  word_t neg_nxt;
  word_t nz_nxt;
  word_t one;
  logic  end_pos;
  logic  end_word;
  logic  emit;
  logic  out_free;

  // insert the current trit at its bit position
  assign one     = word_t'(1) << bit_r;
  assign neg_nxt = neg_acc_r | (trit.neg ? one : '0);
  assign nz_nxt  = nz_acc_r | (trit.nz ? one : '0);

  // word closes on its last bit or on the last channel of a position
  assign end_pos  = idx_r >= last_channel;
  assign end_word = bit_r == LAST_BIT;
  assign emit     = end_pos || end_word;
  assign out_free = !out_valid_r || out_ready;
  assign take     = trit.valid && (!emit || out_free);

  // counters and accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r     <= '0;
      idx_r     <= '0;
      neg_acc_r <= '0;
      nz_acc_r  <= '0;
    end else if (take) begin
      if (emit) begin
        bit_r     <= '0;
        idx_r     <= end_pos ? '0 : idx_r + COUNT_W'(1);
        neg_acc_r <= '0;
        nz_acc_r  <= '0;
      end else begin
        bit_r     <= bit_r + BIT_W'(1);
        idx_r     <= idx_r + COUNT_W'(1);
        neg_acc_r <= neg_nxt;
        nz_acc_r  <= nz_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_neg_r  <= neg_nxt;
      out_nz_r   <= nz_nxt;
      out_last_r <= end_pos;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_negative_mask    = out_neg_r;
  assign out_nonzero_mask     = out_nz_r;
  assign out_last_of_position = out_last_r;

endmodule

// File: design/ternary_quantize_bit_pack.sv
// top level of the ternary quantiser with bit-plane packing
// depends on tqbp_pkg, tqbp_cfg, tqbp_in_stage, tqbp_pack
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | in_sample (Q8.8 signed), in_is_pad
//  out     | out_valid/out_ready  | out_negative_mask, out_nonzero_mask,
//          |                      | out_last_of_position
//  cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data (cfg_ready always high)
//
// one sample per cycle sustained unless the packer stalls; a word pair is offered
// once the beat that closes it is accepted and taken (input register, then result register)
// the packer stalls only when it must emit and the result register is full
// synchronous active-low reset clears counters, accumulators and valids;
// threshold resets to 0 and channel count to 64
module ternary_quantize_bit_pack
  import tqbp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [SAMPLE_W-1:0]   in_sample,
  input  logic                  in_is_pad,
  output logic                  out_valid,
  input  logic                  out_ready,
  output word_t                 out_negative_mask,
  output word_t                 out_nonzero_mask,
  output logic                  out_last_of_position,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [THRESH_W-1:0] threshold;
  logic [COUNT_W-1:0]  last_channel;
  logic                take;
  tqbp_trit_t          trit;

  // configuration registers
  tqbp_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .threshold    (threshold),
    .last_channel (last_channel)
  );

  // input register and ternary decision
  tqbp_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_sample (in_sample),
    .in_is_pad (in_is_pad),
    .threshold (threshold),
    .take      (take),
    .trit      (trit)
  );

  // packing and result register
  tqbp_pack u_pack (
    .clk                  (clk),
    .rst_n                (rst_n),
    .trit                 (trit),
    .last_channel         (last_channel),
    .take                 (take),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_negative_mask    (out_negative_mask),
    .out_nonzero_mask     (out_nonzero_mask),
    .out_last_of_position (out_last_of_position)
  );

endmodule

// File: dv/tb_ternary_quantize_bit_pack.sv
// self-checking testbench for the ternary quantiser with bit-plane packing
// depends on tqbp_pkg and the design top ternary_quantize_bit_pack
module tb_ternary_quantize_bit_pack;
  import tqbp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int COUNT_RESET  = 64;
  localparam int DRAIN_CYCLES = 8;
  localparam int TAIL_CYCLES  = 20;
  localparam int HOLD_CYCLES  = 200;
  localparam int QUIET_LIMIT  = 2000;
  localparam int NUM_PHASES   = 9;
  localparam int PHASE_BEATS  = 130;

  // indexes past the register list, written only to see them ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    logic                pad;
  } sample_beat_t;

  typedef struct {
    word_t neg;
    word_t nz;
    logic  last;
  } planes_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  logic [SAMPLE_W-1:0]   in_sample   = '0;
  logic                  in_is_pad   = 1'b0;
  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  word_t                 out_negative_mask;
  word_t                 out_nonzero_mask;
  logic                  out_last_of_position;
  logic                  cfg_valid   = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;

  sample_beat_t beat_q[$];
  planes_t      planes_q[$];

  // packer model state and its copy of the registers
  logic [THRESH_W-1:0] thresh_r;
  logic [COUNT_W-1:0]  count_r;
  int                  pk_bit;
  int                  pk_chan;
  word_t               neg_acc;
  word_t               nz_acc;

  int   errors        = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic hold_req      = 1'b0;
  logic hold_taken;
  int   hold_left;
  logic in_took;
  int   quiet;

  ternary_quantize_bit_pack dut (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ternarise one sample into the accumulators, queue a word pair when one closes
  function automatic void pack_sample(input logic signed [SAMPLE_W-1:0] s, input logic pad);
    int    t;
    int    eff;
    word_t one;
    bit    end_pos;
    bit    end_word;
    t   = int'(thresh_r);
    eff = (count_r == 0) ? 1 : ((int'(count_r) > MAX_CHANNELS) ? MAX_CHANNELS : int'(count_r));
    one = word_t'(1) << pk_bit;
    if (!pad) begin
      if (int'(s) > t) begin
        nz_acc |= one;
      end else if (int'(s) < -t) begin
        neg_acc |= one;
        nz_acc  |= one;
      end
    end
    end_pos  = pk_chan >= eff - 1;
    end_word = pk_bit >= WORD_BITS - 1;
    if (end_pos || end_word) begin
      planes_q.push_back('{neg_acc, nz_acc, end_pos});
      neg_acc = '0;
      nz_acc  = '0;
      pk_bit  = 0;
      pk_chan = end_pos ? 0 : pk_chan + 1;
    end else begin
      pk_bit  = pk_bit + 1;
      pk_chan = pk_chan + 1;
    end
  endfunction

  // sample handshakes at the rising edge: check results, track registers, predict
  always @(posedge clk) begin : monitor
    planes_t want;
    if (!rst_n) begin
      thresh_r = THRESH_RESET;
      count_r  = COUNT_W'(COUNT_RESET);
      pk_bit   = 0;
      pk_chan  = 0;
      neg_acc  = '0;
      nz_acc   = '0;
      in_took <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (planes_q.size() == 0) begin
          $error("word pair with none expected: neg %h nz %h last %b",
                 out_negative_mask, out_nonzero_mask, out_last_of_position);
          errors++;
        end else begin
          want = planes_q.pop_front();
          if (want.neg !== out_negative_mask) begin
            $error("negative_mask: expected %h, actual %h", want.neg, out_negative_mask);
            errors++;
          end
          if (want.nz !== out_nonzero_mask) begin
            $error("nonzero_mask: expected %h, actual %h", want.nz, out_nonzero_mask);
            errors++;
          end
          if (want.last !== out_last_of_position) begin
            $error("last_of_position: expected %b, actual %b", want.last, out_last_of_position);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_THRESHOLD:     thresh_r = cfg_data[THRESH_W-1:0];
          REG_CHANNEL_COUNT: count_r  = cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) pack_sample($signed(in_sample), in_is_pad);
      in_took <= in_valid && in_ready;
    end
  end

  // sample driver: next beat once the current one is taken, random gaps
  always @(negedge clk) begin : driver
    sample_beat_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (beat_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = beat_q.pop_front();
        in_valid  <= 1'b1;
        in_sample <= nxt.sample;
        in_is_pad <= nxt.pad;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      hold_left  <= 0;
      hold_taken <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      out_ready  <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else begin
      out_ready <= $urandom_range(99) >= recv_idle_pct;
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
    begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic push_beat(input logic [SAMPLE_W-1:0] s, input logic pad);
    beat_q.push_back('{s, pad});
  endtask

  // random sample biased towards the threshold band edges and the extremes
  function automatic logic [SAMPLE_W-1:0] gen_sample(input int thr);
    int v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = int'($urandom_range(65535));
      4, 5, 6: begin
        v = thr + int'($urandom_range(4)) - 2;
        if ($urandom_range(1) == 1) v = -v;
      end
      7:       v = ($urandom_range(1) == 1) ? 32767 : -32768;
      default: v = int'($urandom_range(4)) - 2;
    endcase
    return SAMPLE_W'(v);
  endfunction

  task automatic push_random(input int n, input int thr);
    repeat (n) push_beat(gen_sample(thr), $urandom_range(9) == 0);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // every beat taken, every word pair seen, then let the pipeline settle
  task automatic wait_drained();
    while (beat_q.size() != 0 || in_valid || planes_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // stimulus sequence
  initial begin : stimulus
    int thr;
    int cnt;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset values, threshold zero and a full 64-channel position
    send_idle_pct = 8;
    recv_idle_pct = 48;
    push_beat(16'sd0, 1'b0);
    push_beat(16'sd1, 1'b0);
    push_beat(-16'sd1, 1'b0);
    push_beat(-16'sd32768, 1'b1);
    push_beat(16'sd32767, 1'b0);
    push_beat(-16'sd32768, 1'b0);
    push_random(62, 0);
    wait_drained();

    // count lowered below the channel already reached closes on the next sample;
    // register bits above the field width are dropped
    cfg_write(REG_CHANNEL_COUNT, 16'hE003);
    cfg_write(REG_THRESHOLD, 16'h8100);
    push_beat(16'sd32767, 1'b0);
    push_beat(16'sd32767, 1'b0);
    push_beat(-16'sd32768, 1'b0);
    push_beat(16'sd256, 1'b0);
    push_beat(-16'sd256, 1'b0);
    push_beat(16'sd257, 1'b0);
    push_beat(-16'sd257, 1'b0);
    push_beat(16'sd0, 1'b0);
    push_beat(16'sd32767, 1'b1);
    push_beat(-16'sd32768, 1'b1);
    wait_drained();

    // top threshold, count of zero behaves as one, spare indexes ignored
    cfg_write(REG_THRESHOLD, 16'h7FFF);
    cfg_write(REG_CHANNEL_COUNT, 16'h0000);
    cfg_write(REG_SPARE_A, 16'hFFFF);
    cfg_write(REG_SPARE_B, 16'h0001);
    push_beat(16'sd32767, 1'b0);
    push_beat(-16'sd32768, 1'b0);
    push_beat(-16'sd32767, 1'b0);
    push_beat(16'sd1, 1'b0);

    // random phases, each with its own register setting
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      if (p < 3) begin
        send_idle_pct = 8;
        recv_idle_pct = 48;
      end else if (p < 6) begin
        send_idle_pct = 48;
        recv_idle_pct = 8;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (p)
        0: begin thr = 0;                        cnt = 1;                       end
        1: begin thr = 32767;                    cnt = 65;                      end
        2: begin thr = $urandom_range(32767);    cnt = $urandom_range(40, 2);   end
        3: begin thr = $urandom_range(512);      cnt = 64;                      end
        4: begin thr = $urandom_range(32767);    cnt = 128;                     end
        5: begin thr = 256;                      cnt = $urandom_range(300, 2);  end
        6: begin thr = $urandom_range(2048);     cnt = 8191;                    end
        7: begin thr = 0;                        cnt = $urandom_range(20, 2);   end
        default: begin thr = $urandom_range(1024); cnt = 5;                     end
      endcase
      cfg_write(REG_THRESHOLD, {1'($urandom_range(1)), THRESH_W'(thr)});
      cfg_write(REG_CHANNEL_COUNT, {3'($urandom_range(7)), COUNT_W'(cnt)});
      if (p == NUM_PHASES - 1) hold_req = 1'b1;
      push_random(PHASE_BEATS, thr);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
